// File: src/olt_pkg.sv
// shared types and codes for the ordered list table
package olt_pkg;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_EDIT   = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;
  localparam logic [2:0] MODE_FIND   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // capacity loaded at reset
  localparam logic [6:0] CAP_RESET = 7'd3;

  // request item
  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         position;
    logic signed [31:0] value;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [5:0]         found_position;
    logic [6:0]         element_count;
    logic [7:0]         logical_capacity;
    logic               is_empty;
    logic               is_full;
  } res_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PRIME,
    S_SHIFT,
    S_PUT,
    S_READ,
    S_FIND,
    S_DONE
  } state_t;

  // cursor setup for a walk over the store
  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_INSERT,
    CUR_DELETE,
    CUR_FIND
  } cur_sel_t;

  // memory write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND,
    WR_PUT,
    WR_SHIFT
  } wr_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       capture;
    cur_sel_t   cur_sel;
    logic       advance;
    wr_sel_t    wr_sel;
    logic       read_pos;
    logic       grow_inc;
    logic       dec_shrink;
    logic       take_read;
    logic       take_find;
    logic       set_status;
    logic [2:0] status;
    logic       load_result;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       count_zero;
    logic       count_at_depth;
    logic       pos_gt_count;
    logic       pos_ge_count;
    logic       up_needed;
    logic       down_needed;
    logic       at_end;
    logic       hit;
    logic       slot_free;
  } sts_t;

endpackage

// File: src/olt_ram.sv
// generic single write port ram with registered read
module olt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/olt_ctrl.sv
// controller state machine for the ordered list table
module olt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  olt_pkg::sts_t sts,
  output olt_pkg::ctl_t ctl
);
  import olt_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.mode)
          MODE_INSERT: begin
            priority if (sts.pos_gt_count || sts.count_at_depth) state_next = S_DONE;
            else if (sts.up_needed) state_next = S_PRIME;
            else state_next = S_PUT;
          end
          MODE_DELETE: begin
            priority if (sts.count_zero || sts.pos_ge_count) state_next = S_DONE;
            else if (sts.down_needed) state_next = S_PRIME;
            else state_next = S_DONE;
          end
          MODE_READ: begin
            priority if (sts.count_zero || sts.pos_ge_count) state_next = S_DONE;
            else state_next = S_READ;
          end
          MODE_FIND: begin
            if (sts.count_zero) state_next = S_DONE;
            else state_next = S_PRIME;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_PRIME: begin
        if (sts.mode == MODE_FIND) state_next = S_FIND;
        else state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.at_end) begin
          if (sts.mode == MODE_INSERT) state_next = S_PUT;
          else state_next = S_DONE;
        end
      end
      S_PUT:  state_next = S_DONE;
      S_READ: state_next = S_DONE;
      S_FIND: begin
        if (sts.hit || sts.at_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_stall       = 1'b1;
    ctl.capture     = 1'b0;
    ctl.cur_sel     = CUR_NONE;
    ctl.advance     = 1'b0;
    ctl.wr_sel      = WR_NONE;
    ctl.read_pos    = 1'b0;
    ctl.grow_inc    = 1'b0;
    ctl.dec_shrink  = 1'b0;
    ctl.take_read   = 1'b0;
    ctl.take_find   = 1'b0;
    ctl.set_status  = 1'b0;
    ctl.status      = ST_OK;
    ctl.load_result = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_stall   = 1'b0;
        ctl.capture = cmd_valid;
      end
      S_DECODE: begin
        ctl.set_status = 1'b1;
        unique case (sts.mode)
          MODE_APPEND: begin
            if (sts.count_at_depth) begin
              ctl.status = ST_FULL;
            end else begin
              ctl.wr_sel   = WR_APPEND;
              ctl.grow_inc = 1'b1;
            end
          end
          MODE_INSERT: begin
            priority if (sts.pos_gt_count) ctl.status = ST_BAD_INDEX;
            else if (sts.count_at_depth) ctl.status = ST_FULL;
            else if (sts.up_needed) ctl.cur_sel = CUR_INSERT;
            else ctl.status = ST_OK;
          end
          MODE_EDIT, MODE_DELETE, MODE_READ: begin
            priority if (sts.count_zero) begin
              ctl.status = ST_EMPTY;
            end else if (sts.pos_ge_count) begin
              ctl.status = ST_BAD_INDEX;
            end else if (sts.mode == MODE_EDIT) begin
              ctl.wr_sel = WR_PUT;
            end else if (sts.mode == MODE_READ) begin
              ctl.read_pos = 1'b1;
            end else if (sts.down_needed) begin
              ctl.cur_sel = CUR_DELETE;
            end else begin
              ctl.dec_shrink = 1'b1;
            end
          end
          MODE_FIND: begin
            ctl.status = ST_NOT_FOUND;
            if (!sts.count_zero) ctl.cur_sel = CUR_FIND;
          end
          default: ctl.status = ST_OK;
        endcase
      end
      S_PRIME: begin
        ctl.advance = 1'b1;
      end
      S_SHIFT: begin
        ctl.wr_sel  = WR_SHIFT;
        ctl.advance = 1'b1;
        if (sts.at_end && sts.mode == MODE_DELETE) ctl.dec_shrink = 1'b1;
      end
      S_PUT: begin
        ctl.wr_sel   = WR_PUT;
        ctl.grow_inc = 1'b1;
      end
      S_READ: begin
        ctl.take_read = 1'b1;
      end
      S_FIND: begin
        if (sts.hit) begin
          ctl.take_find  = 1'b1;
          ctl.set_status = 1'b1;
          ctl.status     = ST_OK;
        end else begin
          ctl.advance = 1'b1;
        end
      end
      S_DONE: begin
        ctl.load_result = sts.slot_free;
      end
      default: cmd_stall = 1'b1;
    endcase
  end

endmodule

// File: src/olt_dp.sv
// datapath for the ordered list table: store, counters, cursor, result register
module olt_dp #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  olt_pkg::cmd_t cmd,
  input  logic          cfg_write_enable,
  input  logic [6:0]    cfg_write_data,
  output logic          res_valid,
  input  logic          res_stall,
  output olt_pkg::res_t res,
  input  olt_pkg::ctl_t ctl,
  output olt_pkg::sts_t sts
);
  import olt_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = ($clog2(DEPTH) + 2 > 8) ? $clog2(DEPTH) + 2 : 8;
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // latched item
  logic [2:0]           mode;
  logic [5:0]           pos;
  logic [WORD_BITS-1:0] val;

  // list state
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] cap;

  // walk cursor
  logic [IDX_W-1:0] cursor;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] end_idx;
  logic             descend;

  // result fields under construction
  logic [2:0]           status;
  logic [WORD_BITS-1:0] rd;
  logic [5:0]           fpos;

  // memory port
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // comparison operands
  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] cnt_cmp;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] cnt_idx;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] count_dec;
  logic [CAP_W-1:0] cnt_cap;
  logic [CAP_W-1:0] cnt_dec_cap;
  logic             slot_free;

  assign pos_cmp     = CMP_W'(pos);
  assign cnt_cmp     = CMP_W'(count);
  assign pos_idx     = IDX_W'(pos);
  assign cnt_idx     = IDX_W'(count);
  assign last_idx    = IDX_W'(count - CNT_W'(1));
  assign count_dec   = count - CNT_W'(1);
  assign cnt_cap     = CAP_W'(count);
  assign cnt_dec_cap = CAP_W'(count_dec);
  assign slot_free   = !res_valid || !res_stall;

  // status toward the controller
  assign sts.mode           = mode;
  assign sts.count_zero     = (count == '0);
  assign sts.count_at_depth = (count >= DEPTH_CNT);
  assign sts.pos_gt_count   = (pos_cmp > cnt_cmp);
  assign sts.pos_ge_count   = (pos_cmp >= cnt_cmp);
  assign sts.up_needed      = (pos_cmp < cnt_cmp);
  assign sts.down_needed    = ((pos_cmp + CMP_W'(1)) < cnt_cmp);
  assign sts.at_end         = (last == end_idx);
  assign sts.hit            = (ram_rdata == val);
  assign sts.slot_free      = slot_free;

  // memory write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_idx;
    ram_wdata = val;
    unique case (ctl.wr_sel)
      WR_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_idx;
      end
      WR_PUT: begin
        ram_we = 1'b1;
      end
      WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = descend ? last + IDX_W'(1) : last - IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_raddr = ctl.read_pos ? pos_idx : cursor;

  olt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      mode <= cmd.mode;
      pos  <= cmd.position;
      val  <= WORD_BITS'(cmd.value);
    end
  end

  // count and logical capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CAP_W'(CAP_RESET);
    end else begin
      if (ctl.grow_inc) begin
        count <= count + CNT_W'(1);
        if (cnt_cap >= cap) cap <= cap << 1;
      end else if (ctl.dec_shrink) begin
        count <= count_dec;
        if (cap > CAP_W'(1) && cnt_dec_cap <= (cap >> 1)) cap <= cap >> 1;
      end
      if (cfg_write_enable) begin
        cap <= (cfg_write_data == '0) ? CAP_W'(1) : CAP_W'(cfg_write_data);
      end
    end
  end

  // walk cursor over the store
  always_ff @(posedge clk) begin
    unique case (ctl.cur_sel)
      CUR_INSERT: begin
        cursor  <= last_idx;
        end_idx <= pos_idx;
        descend <= 1'b1;
      end
      CUR_DELETE: begin
        cursor  <= pos_idx + IDX_W'(1);
        end_idx <= last_idx;
        descend <= 1'b0;
      end
      CUR_FIND: begin
        cursor  <= '0;
        end_idx <= last_idx;
        descend <= 1'b0;
      end
      default: begin
        if (ctl.advance) begin
          last   <= cursor;
          cursor <= descend ? cursor - IDX_W'(1) : cursor + IDX_W'(1);
        end
      end
    endcase
  end

  // result fields
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      rd     <= '0;
      fpos   <= '0;
      status <= ST_OK;
    end else begin
      if (ctl.set_status) status <= ctl.status;
      if (ctl.take_read) rd <= ram_rdata;
      if (ctl.take_find) fpos <= 6'(last);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      res.status           <= status;
      res.read_value       <= 32'(rd);
      res.found_position   <= fpos;
      res.element_count    <= 7'(count);
      res.logical_capacity <= 8'(cap);
      res.is_empty         <= (count == '0);
      res.is_full          <= (cnt_cap == cap);
    end
  end

endmodule

// File: src/ordered_list_table.sv
// top level of the ordered list table
//
// A positional list of up to DEPTH signed words. Each request item on the cmd
// channel carries one operation (append, insert, edit, delete, read, find);
// each yields exactly one result item on the res channel with status, count,
// logical capacity and the empty and full flags.
// Both channels move an item at a clock edge where valid is high and stall low.
// States per item, from acceptance to the result being registered:
//   append, edit, refused or unused operations: decode, done
//   read: decode, read, done
//   insert: decode, prime, shift walk, put, done when elements move, else decode, put, done
//   delete: decode, prime, shift walk, done when elements move, else decode, done
//   find: decode, prime, find walk to the first match or the end, done; decode, done if empty
// The walk is set by the store's read and write ports: one entry is read and one moved
// per cycle. A new request is taken in the cycle after the result is loaded
// into the output register, even while that result is still stalled.
// A stalled result holds the output register; the next item then waits in its
// last step until the register frees. Synchronous reset empties the list and
// loads capacity 3; no clearing pass runs, the store is left as it is.
// A cfg write loads the capacity (zero is taken as one) and keeps the data.
module ordered_list_table #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  olt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output olt_pkg::res_t res,
  input  logic          cfg_write_enable,
  input  logic [6:0]    cfg_write_data
);
  import olt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  olt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // store and arithmetic
  olt_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .res              (res),
    .ctl              (ctl),
    .sts              (sts)
  );

endmodule

// File: tb/tb_ordered_list_table.sv
// self-checking testbench for the ordered list table
`timescale 1ns / 1ps

module tb_ordered_list_table;
  import olt_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int LIMIT_CYCLES = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cmd_t               cmd = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_t               res;
  logic               cfg_write_enable = 1'b0;
  logic [6:0]         cfg_write_data = '0;

  // shadow copy of the list and its capacity
  logic signed [31:0] list_words [LIST_DEPTH];
  int unsigned        list_count;
  int unsigned        list_capacity;

  res_t               answers_due [$];
  int unsigned        bad_answers = 0;
  int unsigned        cycle_count = 0;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;

  ordered_list_table #(
    .DEPTH(LIST_DEPTH),
    .WORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // apply one operation to the shadow list and form its answer
  task automatic apply_list_op(input cmd_t c, output res_t r);
    int unsigned i;
    logic [2:0] st;
    logic signed [31:0] rd;
    int unsigned fp;
    st = ST_OK;
    rd = '0;
    fp = 0;
    case (c.mode)
      MODE_APPEND: begin
        if (list_count >= LIST_DEPTH) begin
          st = ST_FULL;
        end else begin
          if (list_count >= list_capacity) list_capacity = list_capacity * 2;
          list_words[6'(list_count)] = c.value;
          list_count++;
        end
      end
      MODE_INSERT: begin
        if (c.position > list_count) begin
          st = ST_BAD_INDEX;
        end else if (list_count >= LIST_DEPTH) begin
          st = ST_FULL;
        end else begin
          if (list_count >= list_capacity) list_capacity = list_capacity * 2;
          for (i = list_count; i > c.position; i--) list_words[6'(i)] = list_words[6'(i - 1)];
          list_words[c.position] = c.value;
          list_count++;
        end
      end
      MODE_EDIT, MODE_DELETE, MODE_READ: begin
        if (list_count == 0) begin
          st = ST_EMPTY;
        end else if (c.position >= list_count) begin
          st = ST_BAD_INDEX;
        end else if (c.mode == MODE_EDIT) begin
          list_words[c.position] = c.value;
        end else if (c.mode == MODE_READ) begin
          rd = list_words[c.position];
        end else begin
          for (i = c.position; i + 1 < list_count; i++) list_words[6'(i)] = list_words[6'(i + 1)];
          list_count--;
          // shrink once the new last index drops below half the capacity
          if (list_capacity > 1 && list_count <= list_capacity / 2)
            list_capacity = list_capacity / 2;
        end
      end
      MODE_FIND: begin
        st = ST_NOT_FOUND;
        for (i = 0; i < list_count; i++) begin
          if (list_words[6'(i)] == c.value) begin
            st = ST_OK;
            fp = i;
            break;
          end
        end
      end
      default: ;
    endcase
    r.status           = st;
    r.read_value       = rd;
    r.found_position   = fp[5:0];
    r.element_count    = list_count[6:0];
    r.logical_capacity = list_capacity[7:0];
    r.is_empty         = (list_count == 0);
    r.is_full          = (list_count == list_capacity);
  endtask

  // compare each accepted answer with the oldest one due
  always @(posedge clk) begin : check_answers
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (answers_due.size() == 0) begin
        bad_answers++;
        if (bad_answers <= 10)
          $display("unrequested answer: st=%0d rd=%0d pos=%0d cnt=%0d cap=%0d e=%b f=%b",
                   res.status, res.read_value, res.found_position, res.element_count,
                   res.logical_capacity, res.is_empty, res.is_full);
      end else begin
        want = answers_due.pop_front();
        if (res !== want) begin
          bad_answers++;
          if (bad_answers <= 10) begin
            $display("answer mismatch: want st=%0d rd=%0d pos=%0d cnt=%0d cap=%0d e=%b f=%b",
                     want.status, want.read_value, want.found_position, want.element_count,
                     want.logical_capacity, want.is_empty, want.is_full);
            $display("                  got st=%0d rd=%0d pos=%0d cnt=%0d cap=%0d e=%b f=%b",
                     res.status, res.read_value, res.found_position, res.element_count,
                     res.logical_capacity, res.is_empty, res.is_full);
          end
        end
      end
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input logic [2:0] mode, input logic [5:0] pos,
                           input logic signed [31:0] value);
    cmd_t c;
    res_t r;
    c.mode     = mode;
    c.position = pos;
    c.value    = value;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      cmd.value <= $urandom;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    apply_list_op(c, r);
    answers_due.push_back(r);
  endtask

  // drop valid and let every answer come back
  task automatic wait_until_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] cap);
    wait_until_idle();
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= cap;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    list_capacity = (cap == 0) ? 1 : cap;
  endtask

  task automatic drain_list();
    while (list_count > 0) send_item(MODE_DELETE, 6'($urandom_range(0, list_count - 1)), '0);
  endtask

  // value mix: small pool for repeats, extremes, stored words, full random
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $signed(32'($urandom_range(0, 6))) - 2;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      5, 6: v = (list_count > 0) ? list_words[6'($urandom_range(0, list_count - 1))] : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // random operation, biased toward growing or shrinking the list
  task automatic send_random_item(input bit fill_bias);
    int unsigned r;
    logic [2:0] mode;
    logic [5:0] pos;
    r = $urandom_range(0, 99);
    if (fill_bias) begin
      if (r < 35)      mode = MODE_APPEND;
      else if (r < 60) mode = MODE_INSERT;
      else if (r < 68) mode = MODE_EDIT;
      else if (r < 78) mode = MODE_DELETE;
      else if (r < 88) mode = MODE_READ;
      else if (r < 97) mode = MODE_FIND;
      else             mode = 3'($urandom_range(6, 7));
    end else begin
      if (r < 10)      mode = MODE_APPEND;
      else if (r < 20) mode = MODE_INSERT;
      else if (r < 30) mode = MODE_EDIT;
      else if (r < 65) mode = MODE_DELETE;
      else if (r < 80) mode = MODE_READ;
      else if (r < 97) mode = MODE_FIND;
      else             mode = 3'($urandom_range(6, 7));
    end
    // mostly in-range positions, some anywhere
    if ($urandom_range(0, 99) < 20)
      pos = 6'($urandom_range(0, 63));
    else if (mode == MODE_INSERT)
      pos = 6'($urandom_range(0, list_count));
    else
      pos = (list_count > 0) ? 6'($urandom_range(0, list_count - 1)) : '0;
    send_item(mode, pos, pick_value());
  endtask

  // operations refused or ignored on an empty list: read, edit, delete, find, insert past the end, unused modes
  task automatic test_empty_list();
    send_item(MODE_READ, 6'd0, '0);
    send_item(MODE_EDIT, 6'd0, 32'sd9);
    send_item(MODE_DELETE, 6'd5, '0);
    send_item(MODE_FIND, 6'd0, '0);
    send_item(MODE_INSERT, 6'd1, 32'sd1);
    send_item(3'd6, 6'd63, -1);
    send_item(3'd7, 6'd0, '0);
  endtask

  // growth, shifts, bad indices, duplicates and shrink on delete
  task automatic test_edit_and_shift();
    send_item(MODE_INSERT, 6'd0, 32'sh7fffffff);
    send_item(MODE_APPEND, 6'd0, 32'sh80000000);
    send_item(MODE_APPEND, 6'd63, -1);
    send_item(MODE_APPEND, 6'd0, '0);
    send_item(MODE_INSERT, 6'd2, 32'sd5);
    send_item(MODE_INSERT, 6'd5, 32'sd5);
    send_item(MODE_INSERT, 6'd63, 32'sd7);
    send_item(MODE_READ, 6'd0, '0);
    send_item(MODE_READ, 6'd5, '0);
    send_item(MODE_READ, 6'd6, '0);
    send_item(MODE_READ, 6'd63, '0);
    send_item(MODE_FIND, 6'd0, 32'sd5);
    send_item(MODE_FIND, 6'd0, 32'sh12345678);
    send_item(MODE_EDIT, 6'd1, 32'sh55555555);
    send_item(MODE_EDIT, 6'd6, 32'sd1);
    send_item(MODE_DELETE, 6'd0, '0);
    send_item(MODE_DELETE, 6'd4, '0);
    send_item(MODE_DELETE, 6'd63, '0);
    send_item(MODE_FIND, 6'd0, 32'sh55555555);
    drain_list();
  endtask

  // fill physical storage, then hit every refusal at the top
  task automatic test_storage_full();
    write_capacity(7'd1);
    while (list_count < LIST_DEPTH) begin
      if ($urandom_range(0, 3) == 0)
        send_item(MODE_INSERT, 6'($urandom_range(0, list_count)), $urandom);
      else
        send_item(MODE_APPEND, '0, $urandom);
    end
    send_item(MODE_APPEND, '0, 32'sd1);
    send_item(MODE_INSERT, 6'd0, 32'sd1);
    send_item(MODE_INSERT, 6'd63, 32'sd1);
    send_item(MODE_READ, 6'd63, '0);
    send_item(MODE_FIND, '0, list_words[6'(LIST_DEPTH - 1)]);
    send_item(MODE_EDIT, 6'd63, 32'sh0f0f0f0f);
    send_item(MODE_DELETE, 6'd63, '0);
    send_item(MODE_INSERT, 6'd63, 32'sd3);
    drain_list();
  endtask

  // register extremes, including a capacity below the current count
  task automatic test_capacity_register();
    write_capacity(7'd0);
    send_item(MODE_APPEND, '0, 32'sd11);
    send_item(MODE_APPEND, '0, 32'sd12);
    send_item(MODE_APPEND, '0, 32'sd13);
    write_capacity(7'd127);
    send_item(MODE_APPEND, '0, 32'sd14);
    send_item(MODE_READ, 6'd2, '0);
    write_capacity(7'd64);
    send_item(MODE_DELETE, 6'd0, '0);
    write_capacity(7'd1);
    send_item(MODE_INSERT, 6'd1, 32'sd15);
    send_item(MODE_FIND, '0, 32'sd15);
    drain_list();
  endtask

  // random traffic in fill and drain stretches, under one idle setting
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned stretch;
    bit fill_bias;
    logic [6:0] cap;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent      = 0;
    fill_bias = 1'b1;
    while (sent < n_items) begin
      // fresh capacity between stretches now and then
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: cap = 7'd0;
          1: cap = 7'd1;
          2: cap = 7'd127;
          3: cap = 7'd64;
          default: cap = 7'($urandom_range(0, 127));
        endcase
        write_capacity(cap);
      end
      stretch = $urandom_range(20, 120);
      if (stretch > n_items - sent) stretch = n_items - sent;
      repeat (stretch) begin
        send_random_item(fill_bias);
        sent++;
      end
      fill_bias = !fill_bias;
    end
  endtask

  initial begin
    list_count     = 0;
    list_capacity  = CAP_RESET;
    send_idle_pct  = 16;
    recv_stall_pct = 75;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_edit_and_shift();
    test_storage_full();
    test_capacity_register();
    test_random_traffic(16, 75, 155);
    test_random_traffic(75, 16, 155);
    test_random_traffic(0, 0, 155);

    wait_until_idle();
    repeat (80) @(posedge clk);
    if (bad_answers == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
